>>> rtl/gfau_pkg.sv
// ----------------------------------------------------------------------------
// gfau_pkg
// Shared types, constants and ROM tables for the GF(2^10) arithmetic unit.
// Field polynomial z^10 + z^3 + 1.
// ----------------------------------------------------------------------------
package gfau_pkg;

	localparam int ELEM_W       = 10;
	localparam int LOG_W        = 11;
	localparam int EXP_W        = 32;
	localparam int CMD_W        = 3;
	localparam int ROM_DEPTH    = 1024;
	localparam int FIELD_ORDER  = 1023;
	localparam int FIELD_POLY   = 1033;
	localparam int EXP_MAX      = 1022;
	// 2^32 is 4 mod 1023, so a negative 32-bit word needs -4, i.e. +1019
	localparam int EXP_NEG_ADJ  = FIELD_ORDER - 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD     = 3'd0,
		CMD_MUL     = 3'd1,
		CMD_DIV     = 3'd2,
		CMD_POW_MOD = 3'd3,
		CMD_LOG     = 3'd4,
		CMD_POW_ELT = 3'd5
	} cmd_t;

	typedef logic [ELEM_W-1:0] rom_t [ROM_DEPTH];

	// Entry 1023 wraps to alpha^1023 = 1; its value is never selected for a result.
	function automatic rom_t build_pow_table();
		rom_t         t;
		logic [ELEM_W:0] k;
		k    = 11'd1;
		t[0] = 10'd1;
		for (int i = 1; i < ROM_DEPTH; i++) begin
			k = {k[ELEM_W-1:0], 1'b0};
			if (k[ELEM_W]) begin
				k = k ^ 11'(FIELD_POLY);
			end
			t[i] = k[ELEM_W-1:0];
		end
		return t;
	endfunction

	function automatic rom_t build_log_table();
		rom_t t;
		rom_t p;
		p = build_pow_table();
		t[0] = '0;
		for (int i = 0; i < FIELD_ORDER; i++) begin
			t[p[i]] = ELEM_W'(i);
		end
		return t;
	endfunction

	localparam rom_t POW_TABLE = build_pow_table();
	localparam rom_t LOG_TABLE = build_log_table();

endpackage

>>> rtl/gfau_if.sv
// ----------------------------------------------------------------------------
// gfau_if
// Request and response channels of the GF(2^10) arithmetic unit.
// ----------------------------------------------------------------------------
interface gfau_req_if;
	logic                                valid;
	logic                                ready;
	logic        [gfau_pkg::CMD_W-1:0]   command;
	logic        [gfau_pkg::ELEM_W-1:0]  operand_a;
	logic        [gfau_pkg::ELEM_W-1:0]  operand_b;
	logic signed [gfau_pkg::EXP_W-1:0]   exponent;

	modport source (output valid, command, operand_a, operand_b, exponent, input ready);
	modport sink   (input valid, command, operand_a, operand_b, exponent, output ready);
endinterface

interface gfau_rsp_if;
	logic                                valid;
	logic                                ready;
	logic        [gfau_pkg::ELEM_W-1:0]  element;
	logic signed [gfau_pkg::LOG_W-1:0]   log_value;
	logic                                error;

	modport source (output valid, element, log_value, error, input ready);
	modport sink   (input valid, element, log_value, error, output ready);
endinterface

>>> rtl/gfau_log_rom.sv
// ----------------------------------------------------------------------------
// gfau_log_rom
// Discrete log ROM, two registered read ports sharing one enable.
// ----------------------------------------------------------------------------
module gfau_log_rom (
	input  logic                          clk,
	input  logic                          en,
	input  logic [gfau_pkg::ELEM_W-1:0]   addr_a,
	input  logic [gfau_pkg::ELEM_W-1:0]   addr_b,
	output logic [gfau_pkg::ELEM_W-1:0]   data_a,
	output logic [gfau_pkg::ELEM_W-1:0]   data_b
);

	always_ff @(posedge clk) begin
		if (en) begin
			data_a <= gfau_pkg::LOG_TABLE[addr_a];
			data_b <= gfau_pkg::LOG_TABLE[addr_b];
		end
	end

endmodule

>>> rtl/gfau_pow_rom.sv
// ----------------------------------------------------------------------------
// gfau_pow_rom
// Antilog ROM (alpha^i), one registered read port.
// ----------------------------------------------------------------------------
module gfau_pow_rom (
	input  logic                          clk,
	input  logic                          en,
	input  logic [gfau_pkg::ELEM_W-1:0]   addr,
	output logic [gfau_pkg::ELEM_W-1:0]   data
);

	always_ff @(posedge clk) begin
		if (en) begin
			data <= gfau_pkg::POW_TABLE[addr];
		end
	end

endmodule

>>> rtl/gf1024_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// gf1024_arithmetic_unit
// GF(2^10) add, multiply, divide, power, log and power-to-element unit.
//
// Usage:
//   req carries one beat per operation (command, operand_a, operand_b,
//   exponent); rsp returns exactly one beat per request, in order
//   (element, log_value, error).
//   rsp.valid rises once the beat reaches the output register;
//   throughput is one beat per cycle unless rsp.ready stalls. Stage 1
//   reads the log ROM and folds the exponent, stage 2 forms the antilog
//   address, stage 3 reads the antilog ROM, stage 4 is the output register.
//   When rsp.ready is low while a response is held, the whole pipeline
//   freezes and req.ready drops in the same cycle; nothing is lost or
//   repeated. req.ready is high whenever the output register is empty or
//   being drained.
//   Reset (arst_n low) clears all valid bits; the ROMs are constant and
//   need no initialization, so requests are taken right after reset.
//   Undefined commands return error with zero data.
// ----------------------------------------------------------------------------
module gf1024_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	gfau_req_if.sink    req,
	gfau_rsp_if.source  rsp
);

	localparam int EW = gfau_pkg::ELEM_W;
	localparam int LW = gfau_pkg::LOG_W;

	logic en;

	// stage 1
	logic                 valid_s1;
	gfau_pkg::cmd_t       cmd_s1;
	logic                 cmd_ok_s1;
	logic [EW-1:0]        a_s1;
	logic [EW-1:0]        b_s1;
	logic [11:0]          esum_s1;
	logic [EW-1:0]        elow_s1;
	logic                 erng_s1;
	logic                 eneg1_s1;
	logic [EW-1:0]        la_s1;
	logic [EW-1:0]        lb_s1;

	// stage 2
	logic                 valid_s2;
	logic [EW-1:0]        paddr_s2;
	logic                 use_pow_s2;
	logic [EW-1:0]        plain_s2;
	logic [LW-1:0]        logv_s2;
	logic                 err_s2;

	// stage 3
	logic                 valid_s3;
	logic                 use_pow_s3;
	logic [EW-1:0]        plain_s3;
	logic [LW-1:0]        logv_s3;
	logic                 err_s3;
	logic [EW-1:0]        pw_s3;

	// stage 4
	logic                 valid_s4;
	logic [EW-1:0]        elem_s4;
	logic [LW-1:0]        logv_s4;
	logic                 err_s4;

	assign en        = !valid_s4 || rsp.ready;
	assign req.ready = en;

	// ---------------- stage 1 ----------------
	logic [11:0] esum_d;
	logic [31:0] x;

	assign x      = req.exponent;
	assign esum_d = 12'(x[9:0]) + 12'(x[19:10]) + 12'(x[29:20]) + 12'(x[31:30])
	              + (x[31] ? 12'(gfau_pkg::EXP_NEG_ADJ) : 12'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1    <= gfau_pkg::cmd_t'(req.command);
			cmd_ok_s1 <= (req.command <= 3'(gfau_pkg::CMD_POW_ELT));
			a_s1      <= req.operand_a;
			b_s1      <= req.operand_b;
			esum_s1   <= esum_d;
			elow_s1   <= x[9:0];
			erng_s1   <= (x[31:10] == '0) && (x[9:0] != '1);
			eneg1_s1  <= (x == '1);
		end
	end

	gfau_log_rom u_log_rom (
		.clk    (clk),
		.en     (en),
		.addr_a (req.operand_a),
		.addr_b (req.operand_b),
		.data_a (la_s1),
		.data_b (lb_s1)
	);

	// ---------------- stage 2 ----------------
	logic [EW:0]   fold;
	logic [EW:0]   rmod;
	logic [EW:0]   lsum;
	logic [EW:0]   lmul;
	logic [EW-1:0] ldiv;
	logic          a_nz;
	logic          b_nz;
	logic [EW-1:0] paddr_d;
	logic          use_pow_d;
	logic [EW-1:0] plain_d;
	logic [LW-1:0] logv_d;
	logic          err_d;

	always_comb begin
		fold = 11'(esum_s1[9:0]) + 11'(esum_s1[11:10]);
		rmod = (fold >= 11'(gfau_pkg::FIELD_ORDER)) ? fold - 11'(gfau_pkg::FIELD_ORDER) : fold;
		lsum = 11'(la_s1) + 11'(lb_s1);
		lmul = (lsum >= 11'(gfau_pkg::FIELD_ORDER)) ? lsum - 11'(gfau_pkg::FIELD_ORDER) : lsum;
		ldiv = (la_s1 >= lb_s1) ? la_s1 - lb_s1
		                        : 10'(11'(la_s1) + 11'(gfau_pkg::FIELD_ORDER) - 11'(lb_s1));
		a_nz = (a_s1 != '0);
		b_nz = (b_s1 != '0);

		paddr_d   = '0;
		use_pow_d = 1'b0;
		plain_d   = '0;
		logv_d    = '0;
		err_d     = 1'b0;
		if (!cmd_ok_s1) begin
			err_d = 1'b1;
		end else begin
			case (cmd_s1)
				gfau_pkg::CMD_ADD: begin
					plain_d = a_s1 ^ b_s1;
				end
				gfau_pkg::CMD_MUL: begin
					paddr_d   = lmul[EW-1:0];
					use_pow_d = a_nz && b_nz;
				end
				gfau_pkg::CMD_DIV: begin
					paddr_d   = ldiv;
					use_pow_d = a_nz && b_nz;
					err_d     = !b_nz;
				end
				gfau_pkg::CMD_POW_MOD: begin
					paddr_d   = rmod[EW-1:0];
					use_pow_d = 1'b1;
				end
				gfau_pkg::CMD_LOG: begin
					logv_d = a_nz ? {1'b0, la_s1} : '1;
				end
				gfau_pkg::CMD_POW_ELT: begin
					paddr_d   = elow_s1;
					use_pow_d = erng_s1;
					err_d     = !erng_s1 && !eneg1_s1;
				end
				default: begin
					err_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			paddr_s2   <= paddr_d;
			use_pow_s2 <= use_pow_d;
			plain_s2   <= plain_d;
			logv_s2    <= logv_d;
			err_s2     <= err_d;
		end
	end

	// ---------------- stage 3 ----------------
	gfau_pow_rom u_pow_rom (
		.clk  (clk),
		.en   (en),
		.addr (paddr_s2),
		.data (pw_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			use_pow_s3 <= use_pow_s2;
			plain_s3   <= plain_s2;
			logv_s3    <= logv_s2;
			err_s3     <= err_s2;
		end
	end

	// ---------------- stage 4 ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			elem_s4 <= use_pow_s3 ? pw_s3 : plain_s3;
			logv_s4 <= logv_s3;
			err_s4  <= err_s3;
		end
	end

	assign rsp.valid     = valid_s4;
	assign rsp.element   = elem_s4;
	assign rsp.log_value = logv_s4;
	assign rsp.error     = err_s4;

endmodule

>>> tb/gfau_checker.sv
// ----------------------------------------------------------------------------
// gfau_checker
// Scoreboard for the GF(2^10) arithmetic unit. Watches the request and
// response channels, computes the expected field result of every request
// beat and compares each response beat with the oldest expectation.
// ----------------------------------------------------------------------------
module gfau_checker
	import gfau_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	gfau_req_if  req,
	gfau_rsp_if  rsp,
	output int   fail_count,
	output int   pending,
	output int   checked
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic [ELEM_W-1:0]        element;
		logic signed [LOG_W-1:0]  log_value;
		logic                     error;
	} field_result_t;

	logic [ELEM_W-1:0] alpha_pow [FIELD_ORDER];
	logic [ELEM_W-1:0] elem_log  [ROM_DEPTH];
	field_result_t     expected_q [$];

	initial begin : build_field
		logic [ELEM_W:0] acc;
		acc = 1;
		for (int i = 0; i < FIELD_ORDER; i++) begin
			alpha_pow[i] = acc[ELEM_W-1:0];
			elem_log[acc[ELEM_W-1:0]] = ELEM_W'(i);
			acc = acc << 1;
			if (acc[ELEM_W]) begin
				acc = acc ^ (ELEM_W+1)'(FIELD_POLY);
			end
		end
		elem_log[0] = '0;
	end

	function automatic field_result_t field_op(
		input logic [CMD_W-1:0]        c,
		input logic [ELEM_W-1:0]       a,
		input logic [ELEM_W-1:0]       b,
		input logic signed [EXP_W-1:0] e
	);
		field_result_t r;
		longint        m;
		r = '0;
		r.command = c;
		case (c)
			CMD_ADD: begin
				r.element = a ^ b;
			end
			CMD_MUL: begin
				if (a != 0 && b != 0) begin
					r.element = alpha_pow[(int'(elem_log[a]) + int'(elem_log[b])) % FIELD_ORDER];
				end
			end
			CMD_DIV: begin
				if (b == 0) begin
					r.error = 1'b1;
				end else if (a != 0) begin
					r.element = alpha_pow[(int'(elem_log[a]) + FIELD_ORDER
						- int'(elem_log[b])) % FIELD_ORDER];
				end
			end
			CMD_POW_MOD: begin
				m = longint'(e) % FIELD_ORDER;
				if (m < 0) begin
					m = m + FIELD_ORDER;
				end
				r.element = alpha_pow[m];
			end
			CMD_LOG: begin
				if (a == 0) begin
					r.log_value = -1;
				end else begin
					r.log_value = LOG_W'(elem_log[a]);
				end
			end
			CMD_POW_ELT: begin
				if (e < -1 || e > EXP_MAX) begin
					r.error = 1'b1;
				end else if (e != -1) begin
					r.element = alpha_pow[e];
				end
			end
			default: begin
				r.error = 1'b1;
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int want_v, input int got_v);
		$display("[%0t] mismatch on response beat %0d, %s: expected %0d, got %0d",
			$realtime, checked, what, want_v, got_v);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		field_result_t want;
		if (!arst_n) begin
			expected_q.delete();
			checked    = 0;
			pending    = 0;
			fail_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("beat with no request outstanding", 0, 1);
				end else begin
					want = expected_q.pop_front();
					if (rsp.element !== want.element) begin
						report_mismatch($sformatf("element (cmd %0d)", want.command),
							int'(want.element), int'(rsp.element));
					end
					if (rsp.log_value !== want.log_value) begin
						report_mismatch($sformatf("log_value (cmd %0d)", want.command),
							int'(want.log_value), int'(rsp.log_value));
					end
					if (rsp.error !== want.error) begin
						report_mismatch($sformatf("error (cmd %0d)", want.command),
							int'(want.error), int'(rsp.error));
					end
				end
				checked++;
			end
			if (req.valid && req.ready) begin
				expected_q.push_back(field_op(req.command, req.operand_a, req.operand_b,
					req.exponent));
			end
			pending = expected_q.size();
		end
	end

endmodule

>>> tb/tb_gf1024_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// tb_gf1024_arithmetic_unit
// Stimulus and verdict for the GF(2^10) arithmetic unit. A directed set
// hits operand and exponent extremes, zero operands, divide by zero and
// undefined commands; random beats follow under three back-pressure mixes.
// ----------------------------------------------------------------------------
module tb_gf1024_arithmetic_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import gfau_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;
	localparam int PHASE_BEATS = 534;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   checked;
	int   sent;
	int   send_idle_pct;
	int   rcv_idle_pct;
	int   cycle_count;

	gfau_req_if req_ch ();
	gfau_rsp_if rsp_ch ();

	gf1024_arithmetic_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	gfau_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d beats outstanding", CYCLE_LIMIT, pending);
		$display("tb_gf1024_arithmetic_unit: FAIL");
		$finish;
	end

	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	task automatic send_op(
		input logic [CMD_W-1:0]        c,
		input logic [ELEM_W-1:0]       a,
		input logic [ELEM_W-1:0]       b,
		input logic signed [EXP_W-1:0] e
	);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.command   <= c;
		req_ch.operand_a <= a;
		req_ch.operand_b <= b;
		req_ch.exponent  <= e;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		sent++;
	endtask

	initial begin
		logic [CMD_W-1:0]        c;
		logic signed [EXP_W-1:0] e;
		int                      pick;
		sent             = 0;
		send_idle_pct    = 0;
		rcv_idle_pct     = 0;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.command   <= CMD_ADD;
		req_ch.operand_a <= '0;
		req_ch.operand_b <= '0;
		req_ch.exponent  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners
		send_op(CMD_ADD, 10'h000, 10'h000, 0);
		send_op(CMD_ADD, 10'h3FF, 10'h2AA, 0);
		send_op(CMD_MUL, 10'h000, 10'h3FF, 0);
		send_op(CMD_MUL, 10'h3FF, 10'h000, 0);
		send_op(CMD_MUL, 10'h3FF, 10'h3FF, 0);
		send_op(CMD_MUL, 10'h001, 10'h155, 0);
		send_op(CMD_DIV, 10'h3FF, 10'h000, 0);
		send_op(CMD_DIV, 10'h000, 10'h000, 0);
		send_op(CMD_DIV, 10'h000, 10'h2AA, 0);
		send_op(CMD_DIV, 10'h3FF, 10'h3FF, 0);
		send_op(CMD_DIV, 10'h001, 10'h3FE, 0);
		send_op(CMD_POW_MOD, 10'h000, 10'h000, 32'sh8000_0000);
		send_op(CMD_POW_MOD, 10'h000, 10'h000, 32'sh7FFF_FFFF);
		send_op(CMD_POW_MOD, 10'h000, 10'h000, -1);
		send_op(CMD_POW_MOD, 10'h000, 10'h000, -1023);
		send_op(CMD_LOG, 10'h000, 10'h000, 0);
		send_op(CMD_LOG, 10'h001, 10'h000, 0);
		send_op(CMD_LOG, 10'h3FF, 10'h3FF, 0);
		send_op(CMD_POW_ELT, 10'h000, 10'h000, -1);
		send_op(CMD_POW_ELT, 10'h000, 10'h000, 0);
		send_op(CMD_POW_ELT, 10'h000, 10'h000, EXP_MAX);
		send_op(CMD_POW_ELT, 10'h000, 10'h000, EXP_MAX + 1);
		send_op(CMD_POW_ELT, 10'h000, 10'h000, -2);
		send_op(CMD_POW_ELT, 10'h3FF, 10'h3FF, 32'sh8000_0000);
		send_op(CMD_RSVD_6, 10'h3FF, 10'h3FF, 32'sh7FFF_FFFF);
		send_op(CMD_RSVD_7, 10'h155, 10'h2AA, -1);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 13;
					rcv_idle_pct  = 68;
				end
				1: begin
					send_idle_pct = 68;
					rcv_idle_pct  = 13;
				end
				default: begin
					send_idle_pct = 0;
					rcv_idle_pct  = 0;
				end
			endcase
			repeat (PHASE_BEATS) begin
				pick = $urandom_range(99);
				if (pick < 2) begin
					c = CMD_RSVD_6;
				end else if (pick < 4) begin
					c = CMD_RSVD_7;
				end else begin
					c = CMD_W'($urandom_range(CMD_POW_ELT));
				end
				case ($urandom_range(3))
					0:       e = $urandom();
					1, 2:    e = int'($urandom_range(EXP_MAX + 1)) - 1;
					default: e = int'($urandom_range(4095)) - 2048;
				endcase
				send_op(c,
					($urandom_range(9) == 0) ? '0 : ELEM_W'($urandom()),
					($urandom_range(9) == 0) ? '0 : ELEM_W'($urandom()),
					e);
			end
		end
		req_ch.valid <= 1'b0;

		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d request beats (directed corners, then random under three",
			sent);
		$display("back-pressure mixes); %0d response beats checked, %0d mismatches.",
			checked, fail_count);
		if (fail_count == 0 && pending == 0 && checked == sent) begin
			$display("tb_gf1024_arithmetic_unit: PASS");
		end else begin
			$display("tb_gf1024_arithmetic_unit: FAIL");
		end
		$finish;
	end

endmodule
